[hdl/top_k_score_index_select_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the top-k score select unit
// Clocked checks on clk_i; one form is masked during reset, one is not.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_INDEX_SELECT_UNIT_MACROS_SVH
`define TOP_K_SCORE_INDEX_SELECT_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TKSIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising clock edge, reset included
`define TKSIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[hdl/tksis_pkg.sv]
// ----------------------------------------------------------------------------
// tksis_pkg
// Shared types and constants of the top-k score select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tksis_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned SCORE_W         = 32;
  localparam int unsigned CLASS_INDEX_W   = 10;
  localparam int unsigned RANK_W          = 3;
  localparam int unsigned TOP_COUNT_W     = 4;

  // Configuration reset value
  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 4'd5;

  // Default sizes
  localparam int unsigned MAX_TOP_DEF     = 8;
  localparam int unsigned MAX_CLASSES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Input item
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      end_of_vector;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [CLASS_INDEX_W-1:0]  class_index;
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] kept_score;
    logic                      last_result;
  } out_item_t;

  // Report queue status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[hdl/tksis_front.sv]
// ----------------------------------------------------------------------------
// tksis_front
// Accepts scores, keeps the sorted best list and hands a finished vector's
// list to the report queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tksis_front #(
  parameter int unsigned MAX_TOP     = tksis_pkg::MAX_TOP_DEF,
  parameter int unsigned MAX_CLASSES = tksis_pkg::MAX_CLASSES_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_TOP + 1),
  localparam int unsigned POS_W      = $clog2(MAX_CLASSES),
  localparam int unsigned ENT_W      = tksis_pkg::SCORE_W + POS_W,
  localparam int unsigned RPT_W      = MAX_TOP * ENT_W + CNT_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tksis_pkg::in_item_t                 in_item_i,
  input  logic [tksis_pkg::TOP_COUNT_W-1:0]   top_count_i,
  input  tksis_pkg::queue_status_t            q_status_i,
  output logic                                push_o,
  output logic [RPT_W-1:0]                    rpt_o
);
  import tksis_pkg::*;

  logic signed [SCORE_W-1:0] best_score_q [MAX_TOP];
  logic signed [SCORE_W-1:0] best_score_d [MAX_TOP];
  logic [POS_W-1:0]          best_pos_q   [MAX_TOP];
  logic [POS_W-1:0]          best_pos_d   [MAX_TOP];
  logic [CNT_W-1:0]          kept_q, kept_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [CNT_W-1:0]          eff_n, cur_cnt, new_cnt;
  logic [MAX_TOP-1:0]        ins, eq;
  logic                      do_ins, accept;

  // Stall only when no report slot is free
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && in_item_i.end_of_vector;

  // Clamp the requested count to 1..MAX_TOP
  always_comb begin
    if (top_count_i == '0) begin
      eff_n = CNT_W'(1);
    end else if (32'(top_count_i) > 32'(MAX_TOP)) begin
      eff_n = CNT_W'(MAX_TOP);
    end else begin
      eff_n = CNT_W'(top_count_i);
    end
    cur_cnt = (kept_q > eff_n) ? eff_n : kept_q;
  end

  // Compare the new score against every kept entry at once
  always_comb begin
    for (int i = 0; i < MAX_TOP; i++) begin
      eq[i]  = (CNT_W'(i) < cur_cnt) && (in_item_i.score == best_score_q[i]);
      ins[i] = (CNT_W'(i) < eff_n) &&
               (!(CNT_W'(i) < cur_cnt) || (in_item_i.score > best_score_q[i]));
    end
    do_ins  = !(|eq) && (|ins);
    new_cnt = (do_ins && (cur_cnt < eff_n)) ? cur_cnt + CNT_W'(1) : cur_cnt;
  end

  // Shift entries below the insertion point down by one
  always_comb begin
    for (int i = 0; i < MAX_TOP; i++) begin
      best_score_d[i] = best_score_q[i];
      best_pos_d[i]   = best_pos_q[i];
      if (do_ins && ins[i]) begin
        if (i == 0 || !ins[(i == 0) ? 0 : i - 1]) begin
          best_score_d[i] = in_item_i.score;
          best_pos_d[i]   = pos_q;
        end else begin
          best_score_d[i] = best_score_q[(i == 0) ? 0 : i - 1];
          best_pos_d[i]   = best_pos_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Pack the updated list for the report queue
  always_comb begin
    rpt_o = '0;
    for (int i = 0; i < MAX_TOP; i++) begin
      rpt_o[i*ENT_W +: ENT_W] = {best_score_d[i], best_pos_d[i]};
    end
    rpt_o[RPT_W-1 -: CNT_W] = new_cnt;
  end

  // Advance the count and the saturating position; clear at end of vector
  always_comb begin
    kept_d = kept_q;
    pos_d  = pos_q;
    if (accept) begin
      if (in_item_i.end_of_vector) begin
        kept_d = '0;
        pos_d  = '0;
      end else begin
        kept_d = new_cnt;
        if (pos_q != POS_W'(MAX_CLASSES - 1)) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
      pos_q  <= '0;
    end else begin
      kept_q <= kept_d;
      pos_q  <= pos_d;
    end
  end

  // Kept entries carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_score_q <= best_score_d;
      best_pos_q   <= best_pos_d;
    end
  end

endmodule

`default_nettype wire

[hdl/tksis_queue.sv]
// ----------------------------------------------------------------------------
// tksis_queue
// Short FIFO of finished reports between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tksis_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tksis_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         data_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         data_o,
  output tksis_pkg::queue_status_t status_o
);
  import tksis_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed report
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/tksis_back.sv]
// ----------------------------------------------------------------------------
// tksis_back
// Walks the report at the queue head and, while the output is not stalled,
// emits one result item per cycle through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tksis_back #(
  parameter int unsigned MAX_TOP     = tksis_pkg::MAX_TOP_DEF,
  parameter int unsigned MAX_CLASSES = tksis_pkg::MAX_CLASSES_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_TOP + 1),
  localparam int unsigned IDX_W      = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1,
  localparam int unsigned POS_W      = $clog2(MAX_CLASSES),
  localparam int unsigned ENT_W      = tksis_pkg::SCORE_W + POS_W,
  localparam int unsigned RPT_W      = MAX_TOP * ENT_W + CNT_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [RPT_W-1:0]         rpt_i,
  input  tksis_pkg::queue_status_t q_status_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tksis_pkg::out_item_t     out_item_o
);
  import tksis_pkg::*;

  logic [IDX_W-1:0] rank_q, rank_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic [ENT_W-1:0] sel;
  logic [CNT_W-1:0] rpt_cnt;
  logic             load, last;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Pick the current entry of the head report
  assign rpt_cnt = rpt_i[RPT_W-1 -: CNT_W];
  assign sel     = rpt_i[rank_q*ENT_W +: ENT_W];
  assign last    = (CNT_W'(rank_q) + CNT_W'(1) == rpt_cnt);
  assign load    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && last;

  // Build the next result and step the rank
  always_comb begin
    out_d             = out_q;
    out_valid_d       = out_valid_q && out_stall_i;
    rank_d            = rank_q;
    if (load) begin
      out_d.class_index = CLASS_INDEX_W'(sel[POS_W-1:0]);
      out_d.rank        = RANK_W'(rank_q);
      out_d.kept_score  = sel[ENT_W-1 -: SCORE_W];
      out_d.last_result = last;
      out_valid_d       = 1'b1;
      rank_d            = last ? '0 : rank_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rank_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rank_q      <= rank_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

[hdl/top_k_score_index_select_unit.sv]
// ----------------------------------------------------------------------------
// top_k_score_index_select_unit
// Streaming top-k selection of Q16.16 class scores with their positions.
// ----------------------------------------------------------------------------
// The unit takes one score per clock and keeps the best top_count scores of
// the current vector, sorted, comparing each new score against all kept
// entries at once; a score equal to a kept one is dropped. An item with
// end_of_vector set is inserted first, then the whole list goes into a
// two-slot report queue and the front starts the next vector on the next
// cycle. The back walks the head report and sends one result per cycle
// unless the output stalls, best first, with last_result on the final one;
// the first result passes through the report queue and the output register
// after the end item is taken. The input stalls only while both report
// slots hold reports not yet fully sent, so the input rate is one item per
// cycle as long as each vector's results drain no slower than vectors arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_index_select_unit #(
  parameter int unsigned MAX_TOP     = tksis_pkg::MAX_TOP_DEF,
  parameter int unsigned MAX_CLASSES = tksis_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tksis_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tksis_pkg::out_item_t              out_item_o,
  input  logic                              cfg_we_i,
  input  logic [tksis_pkg::TOP_COUNT_W-1:0] cfg_wdata_i
);
  import tksis_pkg::*;

`include "top_k_score_index_select_unit_macros.svh"

  localparam int unsigned CNT_W = $clog2(MAX_TOP + 1);
  localparam int unsigned POS_W = $clog2(MAX_CLASSES);
  localparam int unsigned ENT_W = SCORE_W + POS_W;
  localparam int unsigned RPT_W = MAX_TOP * ENT_W + CNT_W;

  logic [TOP_COUNT_W-1:0] top_count_q;
  logic [RPT_W-1:0]       rpt_in, rpt_head;
  logic                   push, pop;
  queue_status_t          q_status;

  // Hold the count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TOP_COUNT_RESET;
    end else if (cfg_we_i) begin
      top_count_q <= cfg_wdata_i;
    end
  end

  tksis_front #(
    .MAX_TOP     (MAX_TOP),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .top_count_i (top_count_q),
    .q_status_i  (q_status),
    .push_o      (push),
    .rpt_o       (rpt_in)
  );

  tksis_queue #(
    .WIDTH (RPT_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (rpt_in),
    .pop_i    (pop),
    .data_o   (rpt_head),
    .status_o (q_status)
  );

  tksis_back #(
    .MAX_TOP     (MAX_TOP),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rpt_i       (rpt_head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Checks on front, queue and back interplay
  `TKSIS_ASSERT(a_push_not_full, push |-> !q_status.full, "report pushed into full queue")
  `TKSIS_ASSERT(a_pop_not_empty, pop |-> !q_status.empty, "report popped from empty queue")
  `TKSIS_ASSERT(a_out_from_report, $rose(out_valid_o) |-> $past(!q_status.empty), "result without report")
  `TKSIS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

`default_nettype wire
